[src/abcm_pkg.sv]
// Shared widths, result codes and table entry type for the ARP binding monitor.
`timescale 1ns / 1ps

package abcm_pkg;

    // Payload widths
    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 32;
    localparam int USED_W    = 9;

    // Default number of table entries
    localparam int TABLE_DEPTH_DEF = 256;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_KNOWN    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd3;

    // One binding table word
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        logic             unsafe;
    } entry_t;

endpackage

[src/abcm_if.sv]
// Valid/ready channel interfaces for observed address pairs and results.
`timescale 1ns / 1ps

interface abcm_in_if;
    import abcm_pkg::*;

    logic             valid;
    logic             ready;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;

    modport source (output valid, output ip_addr, output mac_addr, input ready);
    modport sink   (input valid, input ip_addr, input mac_addr, output ready);
endinterface

interface abcm_out_if;
    import abcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  match_index;
    logic [IP_W-1:0]     bound_ip;
    logic [COUNT_W-1:0]  attack_total;
    logic [USED_W-1:0]   entries_used;
    logic [IP_W-1:0]     last_victim_ip;

    modport source (
        output valid, output status, output match_index, output bound_ip,
        output attack_total, output entries_used, output last_victim_ip,
        input  ready
    );
    modport sink (
        input  valid, input status, input match_index, input bound_ip,
        input  attack_total, input entries_used, input last_victim_ip,
        output ready
    );
endinterface

[src/arp_binding_conflict_monitor.sv]
// Top level: MAC-to-IPv4 binding table with conflict detection.
//
//   Channel | Direction | Beat contents
//   --------+-----------+------------------------------------------------------
//   req     | in        | ip_addr, mac_addr
//   rsp     | out       | status, match_index, bound_ip, attack_total,
//           |           | entries_used, last_victim_ip
//
// One pair is in work at a time. The table memory is scanned one entry a cycle
// from entry 0 up to the first MAC match or the last valid entry. The result beat
// is registered when the scan ends, after between 1 and TABLE_DEPTH entries have been
// compared, and the next pair is taken only once the block is back in idle.
// Reset clears the entry count, attack counter and victim register; the table
// memory needs no clearing since only entries below the count are ever compared.
// A result waiting in the output register stalls the scan at its final compare
// until the register frees up.
`timescale 1ns / 1ps

module arp_binding_conflict_monitor #(
    parameter int TABLE_DEPTH = abcm_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    abcm_in_if.sink    req,
    abcm_out_if.source rsp
);
    import abcm_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Control state
    logic             state_reg,   state_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [COUNT_W-1:0] attack_reg, attack_next;
    logic [IP_W-1:0]  victim_reg,  victim_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    logic [IP_W-1:0]     ip_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [STATUS_W-1:0] status_reg,  status_next;
    logic [INDEX_W-1:0]  index_reg,   index_next;
    logic [IP_W-1:0]     bound_reg,   bound_next;
    logic [USED_W-1:0]   used_reg,    used_next;

    // Memory ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    // Scan decisions
    logic             accept;
    logic             used_zero;
    logic             table_full;
    logic             hit;
    logic             last_entry;
    logic             done;
    logic             out_free;
    logic             commit;
    logic             advance;
    logic             conflict;
    logic             add_entry;
    logic [IDX_W-1:0] idx_sel;
    logic [31:0]      idx_wide;
    logic [31:0]      cnt_wide;

    abcm_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Compare the word read for the current scan index
    assign used_zero  = (count_reg == '0);
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit        = (state_reg == ST_SCAN) && !used_zero && (rd_data.mac == mac_reg);
    assign last_entry = used_zero || ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);
    assign done       = (state_reg == ST_SCAN) && (hit || last_entry);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign commit     = done && out_free;
    assign advance    = (state_reg == ST_SCAN) && !done;
    assign conflict   = hit && (rd_data.ip != ip_reg);
    assign add_entry  = !hit && !table_full;

    // Issue the next read: entry 0 on accept, else the next entry or a re-read
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_addr = '0;
        end
        else if (advance)
        begin
            rd_addr = cmp_idx_reg + IDX_W'(1);
        end
        else
        begin
            rd_addr = cmp_idx_reg;
        end
    end

    // Write back a new binding or the unsafe mark of a conflicting one
    always_comb
    begin
        wr_en   = commit && (conflict || add_entry);
        wr_addr = conflict ? cmp_idx_reg : count_reg[IDX_W-1:0];
        if (conflict)
        begin
            wr_data = '{mac: rd_data.mac, ip: rd_data.ip, unsafe: 1'b1};
        end
        else
        begin
            wr_data = '{mac: mac_reg, ip: ip_reg, unsafe: 1'b0};
        end
    end

    // Build the result and the next counters
    always_comb
    begin
        if (hit)
        begin
            status_next = conflict ? STATUS_CONFLICT : STATUS_KNOWN;
            idx_sel     = cmp_idx_reg;
            bound_next  = rd_data.ip;
        end
        else if (table_full)
        begin
            status_next = STATUS_DROPPED;
            idx_sel     = '0;
            bound_next  = '0;
        end
        else
        begin
            status_next = STATUS_NEW;
            idx_sel     = count_reg[IDX_W-1:0];
            bound_next  = ip_reg;
        end

        count_next  = add_entry ? (count_reg + CNT_W'(1)) : count_reg;
        attack_next = (conflict && (attack_reg != '1)) ? (attack_reg + COUNT_W'(1))
                                                       : attack_reg;
        victim_next = conflict ? ip_reg : victim_reg;

        idx_wide   = 32'(idx_sel);
        cnt_wide   = 32'(count_next);
        index_next = idx_wide[INDEX_W-1:0];
        used_next  = cnt_wide[USED_W-1:0];
    end

    // Sequence the scan
    always_comb
    begin
        state_next     = state_reg;
        cmp_idx_next   = cmp_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_SCAN;
                    cmp_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
                else if (advance)
                begin
                    cmp_idx_next = cmp_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_idx_reg   <= '0;
            count_reg     <= '0;
            attack_reg    <= '0;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_idx_reg   <= cmp_idx_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg  <= count_next;
                attack_reg <= attack_next;
                victim_reg <= victim_next;
            end
        end
    end

    // Hold the pair in work and the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ip_reg  <= req.ip_addr;
            mac_reg <= req.mac_addr;
        end
        if (commit)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            bound_reg  <= bound_next;
            used_reg   <= used_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.match_index    = index_reg;
    assign rsp.bound_ip       = bound_reg;
    assign rsp.attack_total   = attack_reg;
    assign rsp.entries_used   = used_reg;
    assign rsp.last_victim_ip = victim_reg;

    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A new binding grows the count by exactly one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (status_next == STATUS_NEW)) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("new entry did not advance the count");

    // The attack counter moves only on a committed conflict
    a_attack_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit && conflict) |=> $stable(attack_reg))
        else $error("attack counter changed without a conflict");

    // The scan never reads past the valid entries
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && !used_zero) |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("scan index beyond valid entries");

endmodule

[src/abcm_table.sv]
// Binding table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module abcm_table #(
    parameter int DEPTH = abcm_pkg::TABLE_DEPTH_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  abcm_pkg::entry_t wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output abcm_pkg::entry_t rd_data
);
    import abcm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write the addressed word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read of the addressed word
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the MAC-to-IPv4 binding table with conflict detection.
`timescale 1ns / 1ps

module testbench;
    import abcm_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int N_RANDOM    = 1630;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_AT     = 30;
    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 8000;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } addr_pair_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  match_index;
        logic [IP_W-1:0]     bound_ip;
        logic [COUNT_W-1:0]  attack_total;
        logic [USED_W-1:0]   entries_used;
        logic [IP_W-1:0]     last_victim_ip;
    } binding_result_t;

    logic clk;
    logic rst_n;

    abcm_in_if  req_if ();
    abcm_out_if rsp_if ();

    arp_binding_conflict_monitor #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Predicted binding table and counters
    logic [MAC_W-1:0]   bind_mac [TABLE_DEPTH];
    logic [IP_W-1:0]    bind_ip [TABLE_DEPTH];
    logic               bind_unsafe [TABLE_DEPTH];
    int                 bind_used;
    logic [COUNT_W-1:0] attack_cnt;
    logic [IP_W-1:0]    victim_ip;

    // Stimulus side: pairs waiting to go out and the MACs they will have bound
    addr_pair_t       pending_pairs [$];
    logic [MAC_W-1:0] known_macs [$];
    logic [IP_W-1:0]  known_ips [$];
    binding_result_t  expected_results [$];

    int n_items;
    int items_launched;
    int items_accepted;
    int results_seen;
    int send_gap;
    int recv_gap;
    int error_count;
    int status_tally [4];
    int quiet_cycles;
    int hold_cnt;
    logic hold_off;
    logic hold_done;
    addr_pair_t next_pair;

    // Work out the result of one pair and advance the predicted table
    function automatic binding_result_t lookup_binding(input logic [IP_W-1:0] ip,
                                                       input logic [MAC_W-1:0] mac);
        binding_result_t r;
        int hit;
        hit = -1;
        for (int i = 0; i < bind_used; i++)
        begin
            if (hit < 0 && bind_mac[i] == mac)
                hit = i;
        end
        if (hit >= 0)
        begin
            r.match_index = hit[INDEX_W-1:0];
            r.bound_ip    = bind_ip[hit];
            if (bind_ip[hit] == ip)
                r.status = STATUS_KNOWN;
            else
            begin
                r.status         = STATUS_CONFLICT;
                bind_unsafe[hit] = 1'b1;
                victim_ip        = ip;
                if (attack_cnt != '1)
                    attack_cnt = attack_cnt + 1;
            end
        end
        else if (bind_used < TABLE_DEPTH)
        begin
            bind_mac[bind_used]    = mac;
            bind_ip[bind_used]     = ip;
            bind_unsafe[bind_used] = 1'b0;
            r.match_index          = bind_used[INDEX_W-1:0];
            r.bound_ip             = ip;
            r.status               = STATUS_NEW;
            bind_used              = bind_used + 1;
        end
        else
        begin
            r.status      = STATUS_DROPPED;
            r.match_index = '0;
            r.bound_ip    = '0;
        end
        r.attack_total   = attack_cnt;
        r.entries_used   = bind_used[USED_W-1:0];
        r.last_victim_ip = victim_ip;
        return r;
    endfunction

    // Queue a pair and note its MAC if it will be bound
    task automatic queue_pair(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        addr_pair_t p;
        int found;
        found = 0;
        foreach (known_macs[i])
        begin
            if (known_macs[i] == mac)
                found = 1;
        end
        if (!found && known_macs.size() < TABLE_DEPTH)
        begin
            known_macs.push_back(mac);
            known_ips.push_back(ip);
        end
        p.ip  = ip;
        p.mac = mac;
        pending_pairs.push_back(p);
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
            error_count++;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Drive request beats from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid    <= 1'b0;
            req_if.ip_addr  <= '0;
            req_if.mac_addr <= '0;
            items_accepted  <= 0;
            items_launched  = 0;
            send_gap        = 0;
        end
        else
        begin
            // predict on every accepted beat
            if (req_if.valid && req_if.ready)
            begin
                expected_results.push_back(lookup_binding(req_if.ip_addr, req_if.mac_addr));
                items_accepted <= items_accepted + 1;
            end
            // offer the next pair once the current one has gone
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_pairs.size() == 0)
                    req_if.valid <= 1'b0;
                else if (items_launched < n_items - QUIET_TAIL && $urandom_range(0, 3) == 0)
                begin
                    send_gap     = $urandom_range(0, 4);
                    req_if.valid <= 1'b0;
                end
                else
                begin
                    next_pair       = pending_pairs.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.ip_addr  <= next_pair.ip;
                    req_if.mac_addr <= next_pair.mac;
                    items_launched++;
                end
            end
        end
    end

    // Hold the result channel off for one long stretch early in the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt  <= 0;
        end
        else if (hold_off)
        begin
            if (hold_cnt == HOLD_CYCLES - 1)
            begin
                hold_off  <= 1'b0;
                hold_done <= 1'b1;
            end
            else
                hold_cnt <= hold_cnt + 1;
        end
        else if (!hold_done && results_seen == HOLD_AT)
        begin
            hold_off <= 1'b1;
            hold_cnt <= 0;
        end
    end

    // Check result beats against the oldest prediction and drive ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            results_seen <= 0;
            recv_gap     = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen <= results_seen + 1;
                if (results_seen >= items_accepted || expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, rsp_if.status);
                    error_count++;
                end
                else
                begin
                    binding_result_t e;
                    e = expected_results.pop_front();
                    compare_field("status", 64'(e.status), 64'(rsp_if.status));
                    compare_field("match_index", 64'(e.match_index),
                                  64'(rsp_if.match_index));
                    compare_field("bound_ip", 64'(e.bound_ip), 64'(rsp_if.bound_ip));
                    compare_field("attack_total", 64'(e.attack_total),
                                  64'(rsp_if.attack_total));
                    compare_field("entries_used", 64'(e.entries_used),
                                  64'(rsp_if.entries_used));
                    compare_field("last_victim_ip", 64'(e.last_victim_ip),
                                  64'(rsp_if.last_victim_ip));
                    status_tally[e.status]++;
                end
            end
            if (hold_off)
                rsp_if.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rsp_if.ready <= 1'b0;
            end
            else if (results_seen < n_items - QUIET_TAIL && $urandom_range(0, 3) == 0)
            begin
                recv_gap     = $urandom_range(0, 4);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
                $display("[arp_binding_conflict_monitor] ERROR");
                $finish;
            end
        end
    end

    // Build the stimulus, run it and report
    initial
    begin
        logic [63:0]      r64;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        int               kind;
        int               pick;

        rst_n        = 1'b0;
        error_count  = 0;
        quiet_cycles = 0;
        bind_used    = 0;
        attack_cnt   = '0;
        victim_ip    = '0;
        status_tally = '{default: 0};

        // directed: field extremes, new, known and conflict outcomes, repeated conflicts on one entry
        queue_pair(32'h0000_0000, 48'h0000_0000_0000);
        queue_pair(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_pair(32'h0000_0000, 48'h0000_0000_0000);
        queue_pair(32'hFFFF_FFFF, 48'h0000_0000_0000);
        queue_pair(32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        queue_pair(32'h0000_0001, 48'h0000_0000_0000);
        queue_pair(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_pair(32'hAAAA_AAAA, 48'h5555_5555_5555);
        queue_pair(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        queue_pair(32'h5555_5555, 48'h5555_5555_5555);
        queue_pair(32'hAAAA_AAAA, 48'h5555_5555_5555);
        queue_pair(32'h8000_0000, 48'h0000_0000_0001);
        queue_pair(32'h0000_0001, 48'h8000_0000_0000);
        queue_pair(32'h8000_0000, 48'h0000_0000_0001);
        queue_pair(32'h8000_0001, 48'h0000_0000_0001);
        queue_pair(32'hC0A8_0001, 48'h0011_2233_4455);
        queue_pair(32'hC0A8_0002, 48'h0011_2233_4455);
        queue_pair(32'hC0A8_0001, 48'h0011_2233_4455);
        queue_pair(32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF);
        queue_pair(32'h0000_0000, 48'hFFFF_FFFF_FFFE);

        // random: mostly bound MACs reused, fresh MACs fill the table then get dropped
        for (int n = 0; n < N_RANDOM; n++)
        begin
            kind = $urandom_range(0, 99);
            r64  = {$urandom(), $urandom()};
            mac  = r64[MAC_W-1:0];
            ip   = $urandom();
            if (kind < 8)
                ip = (kind < 4) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            if (known_macs.size() != 0 && kind < 65)
            begin
                if ($urandom_range(0, 9) == 0)
                    pick = known_macs.size() - 1;
                else
                    pick = $urandom_range(0, known_macs.size() - 1);
                mac = known_macs[pick];
                if (kind < 35)
                    ip = known_ips[pick];
                else
                begin
                    if (kind < 50)
                        ip = known_ips[pick] ^ (32'h1 << $urandom_range(0, 31));
                    if (ip == known_ips[pick])
                        ip = ip ^ 32'h1;
                end
            end
            queue_pair(ip, mac);
        end
        n_items = pending_pairs.size();

        // hold reset, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every result, then let the block settle
        while (!(items_accepted == n_items && results_seen == n_items))
            @(posedge clk);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results expected, actual none", $time,
                     expected_results.size());
            error_count++;
        end

        $display("Checked %0d address pairs: %0d consistent, %0d bound, %0d conflicts,",
                 n_items, status_tally[STATUS_KNOWN], status_tally[STATUS_NEW],
                 status_tally[STATUS_CONFLICT]);
        $display("%0d dropped on a full table; one %0d-cycle result stall, %0d mismatches",
                 status_tally[STATUS_DROPPED], HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("[arp_binding_conflict_monitor] OK");
        else
            $display("[arp_binding_conflict_monitor] ERROR");
        $finish;
    end

endmodule
